FILE: rtl/core/union_find_connectivity_macros.svh
// assertion helpers for the disjoint-set engine
`ifndef UNION_FIND_CONNECTIVITY_MACROS_SVH
`define UNION_FIND_CONNECTIVITY_MACROS_SVH

// same-cycle implication, checked outside reset
`define UFC_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ufc assertion failed");

// next-cycle implication, checked outside reset
`define UFC_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ufc assertion failed");

`endif

FILE: rtl/core/ufc_pkg.sv
package ufc_pkg;

	localparam int NODE_W  = 11;
	localparam int STAMP_W = 32;
	localparam int COUNT_W = 11;

	localparam logic MODE_UNION   = 1'b0;
	localparam logic MODE_RESTART = 1'b1;

	typedef struct packed {
		logic               mode;
		logic [NODE_W-1:0]  node_a;
		logic [NODE_W-1:0]  node_b;
		logic [STAMP_W-1:0] stamp;
	} item_t;

	typedef struct packed {
		logic [COUNT_W-1:0] components;
		logic               merged;
		logic               all_connected;
		logic [STAMP_W-1:0] stamp_out;
	} result_t;

endpackage

FILE: rtl/core/ufc_ram.sv
module ufc_ram #(
	parameter int WIDTH = 22,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

FILE: rtl/core/union_find_connectivity.sv
// union item: accept, then a WALK and a HALF state per visited non-root node on each walk,
// a WALK read per root, a JOIN state when the roots differ, and DONE to load the result.
// restart item: one parent/size memory write per entry (all MAX_NODES) in CLR, then DONE.
// not ready while an item is at work; one result register, filled when free.
// async reset (arst_n low) starts a clearing pass over all MAX_NODES entries of the
// parent/size memory, during which no item is accepted; config is still taken.
module union_find_connectivity
	import ufc_pkg::*;
#(
	parameter int MAX_NODES = 1024
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [COUNT_W-1:0]  cfg_wdata,
	input  logic                item_valid,
	output logic                item_ready,
	input  item_t               item,
	output logic                res_valid,
	input  logic                res_ready,
	output result_t             res
);

	`include "union_find_connectivity_macros.svh"

	localparam int NW = $clog2(MAX_NODES + 1);
	localparam int AW = $clog2(MAX_NODES);
	localparam int CW = (NW > NODE_W) ? NW : NODE_W;
	localparam logic [NW-1:0] ONE_N = NW'(1);

	localparam logic [2:0] ST_CLR  = 3'd0;
	localparam logic [2:0] ST_IDLE = 3'd1;
	localparam logic [2:0] ST_WALK = 3'd2;
	localparam logic [2:0] ST_HALF = 3'd3;
	localparam logic [2:0] ST_JOIN = 3'd4;
	localparam logic [2:0] ST_DONE = 3'd5;

	logic [2:0]         state_q;
	logic [AW-1:0]      clr_q;
	logic               pend_q;
	logic               phase_q;
	logic [NW-1:0]      set_count_q;
	logic [NW-1:0]      active_q;
	logic [CW-1:0]      node_count_q;
	logic               res_valid_q;
	result_t            res_q;

	logic [NW-1:0]      x_q;
	logic [NW-1:0]      b_q;
	logic [NW-1:0]      ra_q;
	logic [NW-1:0]      sza_q;
	logic [NW-1:0]      szx_q;
	logic [NW-1:0]      join_node_q;
	logic [NW-1:0]      join_size_q;
	logic [STAMP_W-1:0] stamp_q;
	logic               merged_q;

	logic               ram_we;
	logic [AW-1:0]      ram_waddr;
	logic [2*NW-1:0]    ram_wdata;
	logic [AW-1:0]      ram_raddr;
	logic [2*NW-1:0]    ram_rdata;
	logic [NW-1:0]      rd_parent;
	logic [NW-1:0]      rd_size;
	logic [NW-1:0]      rd_node;

	logic               accept;
	logic               at_root;
	logic               do_join;
	logic               a_wins;
	logic [NW-1:0]      child_node;
	logic [NW-1:0]      child_size;
	logic [NW-1:0]      root_node;
	logic [NW-1:0]      sum_size;
	logic [CW-1:0]      na_w;
	logic [CW-1:0]      nb_w;
	logic [CW-1:0]      act_w;
	logic [CW-1:0]      cfg_w;
	logic [CW-1:0]      clamp_w;
	logic               nodes_ok;
	logic               out_free;

	assign rd_parent = ram_rdata[NW-1:0];
	assign rd_size   = ram_rdata[2*NW-1:NW];

	assign item_ready = (state_q == ST_IDLE);
	assign accept     = item_valid && item_ready;
	assign out_free   = !res_valid_q || res_ready;

	assign na_w     = CW'(item.node_a);
	assign nb_w     = CW'(item.node_b);
	assign act_w    = CW'(active_q);
	assign nodes_ok = (na_w != '0) && (na_w <= act_w) && (nb_w != '0) && (nb_w <= act_w);

	assign cfg_w   = node_count_q;
	assign clamp_w = (cfg_w == '0) ? CW'(1) :
		((cfg_w > CW'(MAX_NODES)) ? CW'(MAX_NODES) : cfg_w);

	assign at_root    = (rd_parent == x_q);
	assign do_join    = at_root && phase_q && (x_q != ra_q);
	assign a_wins     = (sza_q > rd_size);
	assign child_node = a_wins ? x_q : ra_q;
	assign child_size = a_wins ? rd_size : sza_q;
	assign root_node  = a_wins ? ra_q : x_q;
	assign sum_size   = sza_q + rd_size;

	// read address: next node to look at
	always_comb begin
		case (state_q)
			ST_IDLE: begin
				rd_node = NW'(item.node_a);
			end
			ST_WALK: begin
				rd_node = at_root ? b_q : rd_parent;
			end
			ST_HALF: begin
				rd_node = rd_parent;
			end
			default: begin
				rd_node = x_q;
			end
		endcase
		ram_raddr = AW'(rd_node - ONE_N);
	end

	// write port
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = clr_q;
		ram_wdata = {ONE_N, NW'(clr_q) + ONE_N};
		case (state_q)
			ST_CLR: begin
				ram_we = 1'b1;
			end
			ST_HALF: begin
				// point x at its grandparent
				ram_we    = 1'b1;
				ram_waddr = AW'(x_q - ONE_N);
				ram_wdata = {szx_q, rd_parent};
			end
			ST_WALK: begin
				if (do_join) begin
					ram_we    = 1'b1;
					ram_waddr = AW'(child_node - ONE_N);
					ram_wdata = {child_size, root_node};
				end
			end
			ST_JOIN: begin
				ram_we    = 1'b1;
				ram_waddr = AW'(join_node_q - ONE_N);
				ram_wdata = {join_size_q, join_node_q};
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	ufc_ram #(
		.WIDTH(2 * NW),
		.DEPTH(MAX_NODES)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLR;
			clr_q        <= '0;
			pend_q       <= 1'b0;
			phase_q      <= 1'b0;
			set_count_q  <= NW'(MAX_NODES);
			active_q     <= NW'(MAX_NODES);
			node_count_q <= CW'(MAX_NODES);
			res_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				node_count_q <= CW'(cfg_wdata);
			end
			if ((state_q == ST_DONE) && out_free) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLR: begin
					if (clr_q == AW'(MAX_NODES - 1)) begin
						clr_q   <= '0;
						state_q <= pend_q ? ST_DONE : ST_IDLE;
					end else begin
						clr_q <= clr_q + AW'(1);
					end
				end
				ST_IDLE: begin
					if (accept) begin
						phase_q <= 1'b0;
						if (item.mode == MODE_RESTART) begin
							set_count_q <= NW'(clamp_w);
							active_q    <= NW'(clamp_w);
							clr_q       <= '0;
							pend_q      <= 1'b1;
							state_q     <= ST_CLR;
						end else if (nodes_ok) begin
							state_q <= ST_WALK;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_WALK: begin
					if (!at_root) begin
						state_q <= ST_HALF;
					end else if (!phase_q) begin
						phase_q <= 1'b1;
					end else if (do_join) begin
						set_count_q <= set_count_q - ONE_N;
						state_q     <= ST_JOIN;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_HALF: begin
					state_q <= ST_WALK;
				end
				ST_JOIN: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						pend_q  <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					x_q      <= NW'(item.node_a);
					b_q      <= NW'(item.node_b);
					stamp_q  <= item.stamp;
					merged_q <= 1'b0;
				end
			end
			ST_WALK: begin
				if (!at_root) begin
					szx_q <= rd_size;
				end else if (!phase_q) begin
					ra_q  <= x_q;
					sza_q <= rd_size;
					x_q   <= b_q;
				end else if (do_join) begin
					join_node_q <= root_node;
					join_size_q <= sum_size;
					merged_q    <= 1'b1;
				end
			end
			ST_HALF: begin
				x_q <= rd_parent;
			end
			ST_DONE: begin
				if (out_free) begin
					res_q.components    <= COUNT_W'(CW'(set_count_q));
					res_q.merged        <= merged_q;
					res_q.all_connected <= (set_count_q == ONE_N);
					res_q.stamp_out     <= stamp_q;
				end
			end
			default: begin
				x_q <= x_q;
			end
		endcase
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	`UFC_ASSERT_IMP(a_half_no_clash, state_q == ST_HALF, ram_waddr != ram_raddr)
	`UFC_ASSERT_IMP(a_count_bound, 1'b1, set_count_q <= active_q)
	`UFC_ASSERT_NXT(a_busy_after_accept, accept, !item_ready)
	`UFC_ASSERT_NXT(a_result_from_done, (state_q != ST_DONE) && !res_valid_q, !res_valid_q)

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 100ps

import ufc_pkg::*;

class union_scoreboard;
	localparam int NODES = 1024;

	bit [NODE_W-1:0]  parent_of [NODES];
	bit [COUNT_W-1:0] tree_size [NODES];
	bit [COUNT_W-1:0] set_count;
	bit [COUNT_W-1:0] live_nodes;
	bit [COUNT_W-1:0] node_count;
	result_t          due_reports [$];
	int               mismatches;

	function new();
		node_count = COUNT_W'(NODES);
		mismatches = 0;
		reset_sets(COUNT_W'(NODES));
	endfunction

	function void reset_sets(bit [COUNT_W-1:0] n);
		for (int i = 0; i < NODES; i++) begin
			parent_of[i] = NODE_W'(i + 1);
			tree_size[i] = COUNT_W'(1);
		end
		set_count  = n;
		live_nodes = n;
	endfunction

	// path halving: each visited node is re-pointed to its grandparent
	function bit [NODE_W-1:0] root_of(bit [NODE_W-1:0] x);
		bit [NODE_W-1:0] up;
		while (parent_of[x - 1] != x) begin
			up = parent_of[x - 1];
			parent_of[x - 1] = parent_of[up - 1];
			x = parent_of[x - 1];
		end
		return x;
	endfunction

	function void note_item(item_t it);
		result_t          r;
		bit [COUNT_W-1:0] n;
		bit [NODE_W-1:0]  ra;
		bit [NODE_W-1:0]  rb;
		bit               joined;
		joined = 1'b0;
		if (it.mode == MODE_RESTART) begin
			n = node_count;
			if (n < 1)
				n = COUNT_W'(1);
			if (n > NODES)
				n = COUNT_W'(NODES);
			reset_sets(n);
		end else if (it.node_a >= 1 && it.node_a <= live_nodes &&
		             it.node_b >= 1 && it.node_b <= live_nodes) begin
			ra = root_of(it.node_a);
			rb = root_of(it.node_b);
			if (ra != rb) begin
				if (tree_size[ra - 1] > tree_size[rb - 1]) begin
					parent_of[rb - 1] = ra;
					tree_size[ra - 1] += tree_size[rb - 1];
				end else begin
					parent_of[ra - 1] = rb;
					tree_size[rb - 1] += tree_size[ra - 1];
				end
				set_count--;
				joined = 1'b1;
			end
		end
		r.components    = set_count;
		r.merged        = joined;
		r.all_connected = (set_count == 1);
		r.stamp_out     = it.stamp;
		due_reports.push_back(r);
	endfunction

	function void check_result(result_t got);
		result_t want;
		if (due_reports.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("result beat with nothing expected: components %0d stamp %h",
				         got.components, got.stamp_out);
			return;
		end
		want = due_reports.pop_front();
		if (got.components !== want.components || got.merged !== want.merged ||
		    got.all_connected !== want.all_connected || got.stamp_out !== want.stamp_out) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch: expected components %0d merged %b connected %b stamp %h, %s",
				         want.components, want.merged, want.all_connected, want.stamp_out,
				         $sformatf("got components %0d merged %b connected %b stamp %h",
				                   got.components, got.merged, got.all_connected,
				                   got.stamp_out));
		end
	endfunction
endclass

module testbench;
	localparam int MAX_NODES    = 1024;
	localparam int LIMIT        = 1000000;
	localparam int RANDOM_ITEMS = 1400;

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic [COUNT_W-1:0] cfg_wdata;
	logic               item_valid;
	logic               item_ready;
	item_t              item;
	logic               res_valid;
	logic               res_ready;
	result_t            res;

	int              send_idle;
	int              recv_idle;
	int              random_sent;
	union_scoreboard sb;

	union_find_connectivity #(
		.MAX_NODES(MAX_NODES)
	) u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res        (res)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		repeat (LIMIT) @(posedge clk);
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		forever begin
			@(posedge clk);
			if (arst_n && res_valid && res_ready)
				sb.check_result(res);
			@(negedge clk);
			res_ready <= ($urandom_range(0, 99) >= recv_idle);
		end
	end

	function automatic void set_pace();
		if (random_sent < RANDOM_ITEMS / 3) begin
			send_idle = 35;
			recv_idle = 82;
		end else if (random_sent < 2 * RANDOM_ITEMS / 3) begin
			send_idle = 82;
			recv_idle = 35;
		end else begin
			send_idle = 0;
			recv_idle = 0;
		end
	endfunction

	task automatic send_item(input item_t it);
		while ($urandom_range(0, 99) < send_idle) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item_valid <= 1'b1;
		item       <= it;
		@(posedge clk);
		while (!item_ready)
			@(posedge clk);
		sb.note_item(it);
		@(negedge clk);
	endtask

	task automatic send_union(input logic [NODE_W-1:0] a, input logic [NODE_W-1:0] b,
	                          input logic [STAMP_W-1:0] stamp);
		item_t it;
		it.mode   = MODE_UNION;
		it.node_a = a;
		it.node_b = b;
		it.stamp  = stamp;
		send_item(it);
	endtask

	task automatic send_restart(input logic [STAMP_W-1:0] stamp);
		item_t it;
		it.mode   = MODE_RESTART;
		it.node_a = NODE_W'($urandom_range(0, 2047));
		it.node_b = NODE_W'($urandom_range(0, 2047));
		it.stamp  = stamp;
		send_item(it);
	endtask

	task automatic drain();
		item_valid <= 1'b0;
		while (sb.due_reports.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_node_count(input logic [COUNT_W-1:0] value);
		drain();
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		sb.node_count = value;
	endtask

	task automatic send_random_edge();
		item_t it;
		int    pick;
		pick     = $urandom_range(0, 99);
		it.stamp = $urandom;
		if (pick < 3) begin
			it.mode   = MODE_RESTART;
			it.node_a = NODE_W'($urandom_range(0, 2047));
			it.node_b = NODE_W'($urandom_range(0, 2047));
		end else if (pick < 11) begin
			it.mode   = MODE_UNION;
			it.node_a = NODE_W'($urandom_range(0, 2047));
			it.node_b = NODE_W'($urandom_range(0, 2047));
		end else begin
			it.mode   = MODE_UNION;
			it.node_a = NODE_W'($urandom_range(1, sb.live_nodes));
			it.node_b = NODE_W'($urandom_range(1, sb.live_nodes));
		end
		send_item(it);
		random_sent++;
		set_pace();
	endtask

	initial begin : stimulus
		int                 pick;
		int                 edges;
		logic [COUNT_W-1:0] value;

		arst_n      = 1'b0;
		cfg_we      = 1'b0;
		cfg_wdata   = '0;
		item_valid  = 1'b0;
		item        = '0;
		res_ready   = 1'b0;
		random_sent = 0;
		sb          = new();
		set_pace();
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;

		write_node_count(11'd1024);
		send_union(11'd1, 11'd1024, 32'h0000_0000);
		send_union(11'd1024, 11'd1, 32'hffff_ffff);
		send_union(11'd0, 11'd5, $urandom);
		send_union(11'd5, 11'd0, $urandom);
		send_union(11'd7, 11'd1025, $urandom);
		send_union(11'd2047, 11'd2047, $urandom);
		send_union(11'd3, 11'd3, $urandom);
		send_union(11'd2, 11'd3, $urandom);
		send_union(11'd4, 11'd2, $urandom);
		write_node_count(11'd0);
		send_union(11'd1, 11'd2, $urandom);
		send_restart(32'h1234_5678);
		send_union(11'd1, 11'd1, $urandom);
		send_union(11'd1, 11'd2, $urandom);
		write_node_count(11'd2047);
		send_restart($urandom);
		write_node_count(11'd2);
		send_restart($urandom);
		send_union(11'd1, 11'd2, $urandom);
		send_union(11'd2, 11'd1, $urandom);
		write_node_count(11'd3);
		send_union(11'd1, 11'd3, $urandom);
		send_restart($urandom);
		send_union(11'd3, 11'd1, $urandom);
		send_union(11'd2, 11'd3, $urandom);

		while (random_sent < RANDOM_ITEMS) begin
			pick = $urandom_range(0, 9);
			case (pick)
				0: begin
					value = 11'd1;
					edges = 4;
				end
				1: begin
					value = 11'd0;
					edges = 4;
				end
				2: begin
					value = 11'd2047;
					edges = $urandom_range(40, 80);
				end
				3: begin
					value = 11'd1024;
					edges = $urandom_range(40, 80);
				end
				4, 5, 6: begin
					value = COUNT_W'($urandom_range(2, 16));
					edges = $urandom_range(value, 3 * value + 4);
				end
				default: begin
					value = COUNT_W'($urandom_range(17, 64));
					edges = $urandom_range(value, 2 * value);
				end
			endcase
			write_node_count(value);
			// new count not applied until the restart beat
			if ($urandom_range(0, 3) == 0)
				repeat (3) send_random_edge();
			send_restart($urandom);
			random_sent++;
			set_pace();
			repeat (edges) send_random_edge();
		end

		drain();
		repeat (MAX_NODES + 64) @(negedge clk);
		if (sb.mismatches == 0 && sb.due_reports.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule
